[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL, included by the line decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition on every rising clock edge outside of reset.
`define ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that an antecedent is followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/erld_pkg.sv]
`timescale 1ns / 1ps

package erld_pkg;

    localparam int CODE_W   = 8;
    localparam int WIDTH_W  = 9;
    localparam int COUNT_W  = 8;
    localparam int MODE_W   = 3;
    localparam int OFFS_W   = 16;
    localparam int LEN_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PHASE_W  = 2;

    localparam int SCREEN_PITCH_DEF = 320;

    localparam logic [CODE_W-1:0] ESCAPE_BYTE = 8'h7f;

    // Decoder phases.
    localparam logic [PHASE_W-1:0] PH_LITERAL = 2'd0;
    localparam logic [PHASE_W-1:0] PH_COUNT   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_VALUE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE = 2'd2;

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST  = 9'd320;
    localparam logic [COUNT_W-1:0] LINE_COUNT_RST  = 8'd200;
    localparam logic [MODE_W-1:0]  LAYOUT_MODE_RST = 3'd0;

    // Layout modes with special meaning.
    localparam logic [MODE_W-1:0] MODE_PITCH        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIRROR_PITCH = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MIRROR       = 3'd5;

    typedef struct packed {
        logic                  image_done;
        logic                  overrun;
        logic                  descending;
        logic [LEN_W-1:0]      run_length;
        logic [OFFS_W-1:0]     start_offset;
        logic [CODE_W-1:0]     pixel_value;
    } run_desc_t;

endpackage

[hw/rtl/escape_rle_line_decoder.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Ports                     | Contents
// ---------+-----------+---------------------------+------------------------------------------
// s_       | in        | s_tvalid/s_tready/s_tdata | one compressed code byte per transaction
// m_       | out       | m_tvalid/m_tready/m_tdata | one run descriptor per transaction,
//          |           | m_tuser/m_tlast           | tlast marks the run that ends the image
// cfg_     | in        | cfg_wen/cfg_index/cfg_wdata | line width, line count, layout mode
//
// One code byte is accepted per cycle, back to back, while the output is not stalled. The byte is
// captured in the input register; the phase logic and the offset adder then build the descriptor,
// which is registered in the output register. Escape and count bytes produce no transaction at
// the output. Reset (aresetn, synchronous) returns the decoder to the literal phase at the frame
// start and restores the register defaults. When the output stalls, its register holds the
// descriptor and one more byte waits before s_tready drops.

module escape_rle_line_decoder
    import erld_pkg::*;
#(
    parameter int SCREEN_PITCH = SCREEN_PITCH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CODE_W-1:0]     s_tdata,   // [7:0] code_byte

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [7:0] pixel_value, [23:8] start_offset,
                                             // [31:24] run_length
    output logic [1:0]            m_tuser,   // [0] descending, [1] overrun
    output logic                  m_tlast,   // image_done

    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

    localparam logic [OFFS_W-1:0] PITCH = OFFS_W'(SCREEN_PITCH);

    // Configuration registers.
    logic [WIDTH_W-1:0] line_width_reg;
    logic [COUNT_W-1:0] line_count_reg;
    logic [MODE_W-1:0]  layout_mode_reg;

    // Input register.
    logic               in_valid_reg;
    logic [CODE_W-1:0]  in_byte_reg;

    // Decoder state.
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [COUNT_W-1:0] pending_reg, pending_next;
    logic [WIDTH_W-1:0] cols_reg,    cols_next;
    logic [COUNT_W-1:0] rows_reg,    rows_next;
    logic [OFFS_W-1:0]  base_reg,    base_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    run_desc_t          out_reg,       out_next;

    logic               out_free;
    logic               advance;
    logic               emit;
    logic               is_value;
    logic [LEN_W-1:0]   run_count;
    logic [WIDTH_W-1:0] eff_width;
    logic [COUNT_W-1:0] eff_count;
    logic               mirror;
    logic [OFFS_W-1:0]  stride;
    logic               over;
    logic [LEN_W-1:0]   run_len;
    logic [WIDTH_W-1:0] cols_after;
    logic [COUNT_W-1:0] rows_dec;
    logic               line_end;
    logic               image_end;
    logic               count_step;

    // The output register can take a descriptor when it is empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg  <= LINE_WIDTH_RST;
            line_count_reg  <= LINE_COUNT_RST;
            layout_mode_reg <= LAYOUT_MODE_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_wdata;
                CFG_LINE_COUNT:  line_count_reg  <= cfg_wdata[COUNT_W-1:0];
                CFG_LAYOUT_MODE: layout_mode_reg <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Zero width or count registers behave as one.
    assign eff_width = (line_width_reg == '0) ? WIDTH_W'(1) : line_width_reg;
    assign eff_count = (line_count_reg == '0) ? COUNT_W'(1) : line_count_reg;
    assign mirror    = (layout_mode_reg == MODE_MIRROR_PITCH) ||
                       (layout_mode_reg == MODE_MIRROR);
    assign stride    = ((layout_mode_reg == MODE_PITCH) ||
                        (layout_mode_reg == MODE_MIRROR_PITCH))
                       ? PITCH : OFFS_W'(eff_width);

    // A value byte closes an escape; any phase but the count and value phases reads as literal.
    assign is_value  = (phase_reg == PH_VALUE);
    assign run_count = is_value ? pending_reg : LEN_W'(1);
    assign emit      = is_value ? (pending_reg != '0)
                     : ((phase_reg != PH_COUNT) && (in_byte_reg != ESCAPE_BYTE));

    // Runs that do not fit in the rest of the line are cut at the line end.
    assign over       = WIDTH_W'(run_count) > cols_reg;
    assign run_len    = over ? cols_reg[LEN_W-1:0] : run_count;
    assign cols_after = cols_reg - WIDTH_W'(run_len);
    assign line_end   = (cols_after == '0);
    assign rows_dec   = rows_reg - COUNT_W'(1);
    assign image_end  = line_end && (rows_dec == '0);

    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        cols_next    = cols_reg;
        rows_next    = rows_reg;
        base_next    = base_reg;

        out_next.pixel_value  = in_byte_reg;
        out_next.start_offset = mirror
            ? (base_reg + OFFS_W'(cols_reg) - OFFS_W'(1))
            : (base_reg + OFFS_W'(eff_width) - OFFS_W'(cols_reg));
        out_next.run_length   = run_len;
        out_next.descending   = mirror;
        out_next.overrun      = over;
        out_next.image_done   = image_end;

        if (advance) begin
            case (phase_reg)
                PH_COUNT: begin
                    pending_next = in_byte_reg;
                    phase_next   = PH_VALUE;
                end
                PH_VALUE: begin
                    phase_next = PH_LITERAL;
                end
                default: begin
                    phase_next = (in_byte_reg == ESCAPE_BYTE) ? PH_COUNT : PH_LITERAL;
                end
            endcase

            if (emit) begin
                cols_next = cols_after;
                if (line_end) begin
                    cols_next = eff_width;
                    if (image_end) begin
                        rows_next = eff_count;
                        base_next = '0;
                    end else begin
                        rows_next = rows_dec;
                        base_next = base_reg + stride;
                    end
                end
            end
        end

        out_valid_next = out_free ? (advance && emit) : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LITERAL;
            pending_reg   <= '0;
            cols_reg      <= LINE_WIDTH_RST;
            rows_reg      <= LINE_COUNT_RST;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.run_length, out_reg.start_offset, out_reg.pixel_value};
    assign m_tuser  = {out_reg.overrun, out_reg.descending};
    assign m_tlast  = out_reg.image_done;

    assign count_step = advance && (phase_reg == PH_COUNT);

    // The column and row counters reload before reaching zero.
    `ASSERT_HOLDS(a_cols_nonzero, aclk, aresetn, cols_reg != '0, "columns left reached zero")
    `ASSERT_HOLDS(a_rows_nonzero, aclk, aresetn, rows_reg != '0, "rows left reached zero")
    // A delivered descriptor always covers at least one pixel.
    `ASSERT_HOLDS(a_len_nonzero, aclk, aresetn, !m_tvalid || (m_tdata[31:24] != '0), "empty run")
    // A count byte is always followed by the value phase.
    `ASSERT_NEXT(a_count_to_value, aclk, aresetn, count_step, is_value, "value phase missed")

endmodule
